// ----- rtl/core/dav_pkg.sv -----
package dav_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF    = 32;

    localparam int GAIN_WIDTH      = 16;
    localparam int OFFSET_WIDTH    = 21;
    localparam int WINDOW_WIDTH    = 8;
    localparam int SPEED_WIDTH     = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 21;

    localparam logic [GAIN_WIDTH-1:0]   GAIN_ONE_RST  = 16'd9190;
    localparam logic [GAIN_WIDTH-1:0]   GAIN_TWO_RST  = 16'd11296;
    localparam logic [OFFSET_WIDTH-1:0] GRAVITY_RST   = 21'd642908;
    localparam logic [OFFSET_WIDTH-1:0] THRESHOLD_RST = 21'd19661;
    localparam logic [WINDOW_WIDTH-1:0] WINDOW_RST    = 8'd200;
    localparam logic [OFFSET_WIDTH-1:0] STOP_BAND_RST = 21'd1311;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_GAIN_ONE,
        CFG_GAIN_TWO,
        CFG_GRAVITY,
        CFG_THRESHOLD,
        CFG_WINDOW,
        CFG_STOP_BAND
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE_ONE,
        ST_SCALE_TWO,
        ST_ACCUM,
        ST_DIV_ONE,
        ST_WAIT_ONE,
        ST_DIV_TWO,
        ST_WAIT_TWO,
        ST_FINISH,
        ST_OUT
    } t_state;

    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // scaled, gravity-corrected acceleration width
    function automatic int f_accel_width(input int sample_width);
        return f_max(sample_width + 9, OFFSET_WIDTH + 1) + 1;
    endfunction

endpackage

// ----- rtl/core/dual_accel_velocity_integrator.sv -----
// sequence: an item that does not close a window passes through scale channel 1,
// scale channel 2 and accumulate, then back to idle; one shared multiplier for both channels
// an item that closes a window then runs divide and wait for each channel, finish and output:
// the shared divider yields one quotient bit per cycle, once per channel
// a new item is taken only in idle; o_stall is high while busy
// reset: synchronous active low, restores register defaults and clears sums and speeds
module dual_accel_velocity_integrator #(
    parameter int SAMPLE_WIDTH = dav_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_WIDTH    = dav_pkg::ACC_WIDTH_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]              i_raw_one,
    input  logic signed [SAMPLE_WIDTH-1:0]              i_raw_two,
    output logic                                        o_valid,
    input  logic                                        i_stall,
    output logic signed [dav_pkg::SPEED_WIDTH-1:0]      o_speed_one,
    output logic signed [dav_pkg::SPEED_WIDTH-1:0]      o_speed_two,
    output logic                                        o_stopped,
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic        [dav_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic        [dav_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);

    localparam int AW   = dav_pkg::f_accel_width(SAMPLE_WIDTH);
    localparam int SUMW = dav_pkg::f_max(ACC_WIDTH, AW) + 1;
    localparam int QW   = ACC_WIDTH + 1;
    localparam int SPW  = dav_pkg::SPEED_WIDTH;
    localparam int VW   = dav_pkg::f_max(QW, SPW) + 1;
    localparam int BW   = SPW + 2;
    localparam int GW   = dav_pkg::GAIN_WIDTH;
    localparam int OW   = dav_pkg::OFFSET_WIDTH;
    localparam int NW   = dav_pkg::WINDOW_WIDTH;

    localparam logic signed [SUMW-1:0] SUM_MAX = {{(SUMW - ACC_WIDTH + 1){1'b0}},
                                                  {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [SUMW-1:0] SUM_MIN = ~SUM_MAX;
    localparam logic signed [VW-1:0]   SPD_MAX = {{(VW - SPW + 1){1'b0}}, {(SPW - 1){1'b1}}};
    localparam logic signed [VW-1:0]   SPD_MIN = ~SPD_MAX;

    dav_pkg::t_state r_state;
    dav_pkg::t_state n_state;

    // configuration
    logic [GW-1:0] r_gain_one;
    logic [GW-1:0] r_gain_two;
    logic [OW-1:0] r_gravity;
    logic [OW-1:0] r_threshold;
    logic [NW-1:0] r_window;
    logic [OW-1:0] r_band;

    // state
    logic signed [ACC_WIDTH-1:0] r_sum_one;
    logic signed [ACC_WIDTH-1:0] r_sum_two;
    logic signed [SPW-1:0]       r_prev_one;
    logic signed [SPW-1:0]       r_prev_two;
    logic        [NW-1:0]        r_cnt;

    // working registers
    logic signed [SAMPLE_WIDTH-1:0] r_raw_one;
    logic signed [SAMPLE_WIDTH-1:0] r_raw_two;
    logic signed [AW-1:0]           r_acc_one;
    logic signed [QW-1:0]           r_quo_one;
    logic signed [QW-1:0]           r_quo_two;
    logic signed [SPW-1:0]          r_v_one;
    logic signed [SPW-1:0]          r_v_two;
    logic                           r_out_valid;
    logic signed [SPW-1:0]          r_out_one;
    logic signed [SPW-1:0]          r_out_two;
    logic                           r_out_stop;

    // control from the sequencer
    logic w_accept;
    logic w_sel_two;
    logic w_div_start;
    logic w_load;
    logic w_out_free;

    // shared scale unit
    logic signed [SAMPLE_WIDTH-1:0] w_scale_raw;
    logic        [GW-1:0]           w_scale_gain;
    logic signed [AW-1:0]           w_accel;

    // accumulate
    logic        [AW-1:0]        w_mag_one;
    logic        [AW-1:0]        w_mag_two;
    logic        [AW-1:0]        w_thr_ext;
    logic                        w_quiet;
    logic signed [AW-1:0]        w_add_one;
    logic signed [AW-1:0]        w_add_two;
    logic signed [SUMW-1:0]      w_tot_one;
    logic signed [SUMW-1:0]      w_tot_two;
    logic signed [ACC_WIDTH-1:0] w_sat_one;
    logic signed [ACC_WIDTH-1:0] w_sat_two;
    logic        [NW-1:0]        w_cnt_nx;
    logic        [NW-1:0]        w_len;
    logic                        w_window_end;

    // divide, finish, stop check
    logic signed [ACC_WIDTH-1:0] w_div_dividend;
    logic                        w_div_done;
    logic signed [QW-1:0]        w_div_quo;
    logic signed [VW-1:0]        w_vsum_one;
    logic signed [VW-1:0]        w_vsum_two;
    logic signed [SPW-1:0]       w_vsat_one;
    logic signed [SPW-1:0]       w_vsat_two;
    logic signed [BW-1:0]        w_v_ext;
    logic signed [BW-1:0]        w_band_ext;
    logic signed [BW-1:0]        w_hi;
    logic signed [BW-1:0]        w_lo;
    logic                        w_stop;

    // ---------------- configuration port ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_one  <= dav_pkg::GAIN_ONE_RST;
            r_gain_two  <= dav_pkg::GAIN_TWO_RST;
            r_gravity   <= dav_pkg::GRAVITY_RST;
            r_threshold <= dav_pkg::THRESHOLD_RST;
            r_window    <= dav_pkg::WINDOW_RST;
            r_band      <= dav_pkg::STOP_BAND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (dav_pkg::t_cfg_index'(i_cfg_index))
                dav_pkg::CFG_GAIN_ONE:  r_gain_one  <= i_cfg_data[GW-1:0];
                dav_pkg::CFG_GAIN_TWO:  r_gain_two  <= i_cfg_data[GW-1:0];
                dav_pkg::CFG_GRAVITY:   r_gravity   <= i_cfg_data[OW-1:0];
                dav_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[OW-1:0];
                dav_pkg::CFG_WINDOW:    r_window    <= i_cfg_data[NW-1:0];
                dav_pkg::CFG_STOP_BAND: r_band      <= i_cfg_data[OW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dav_pkg::ST_IDLE:      if (i_valid) n_state = dav_pkg::ST_SCALE_ONE;
            dav_pkg::ST_SCALE_ONE: n_state = dav_pkg::ST_SCALE_TWO;
            dav_pkg::ST_SCALE_TWO: n_state = dav_pkg::ST_ACCUM;
            dav_pkg::ST_ACCUM: begin
                n_state = w_window_end ? dav_pkg::ST_DIV_ONE : dav_pkg::ST_IDLE;
            end
            dav_pkg::ST_DIV_ONE:   n_state = dav_pkg::ST_WAIT_ONE;
            dav_pkg::ST_WAIT_ONE:  if (w_div_done) n_state = dav_pkg::ST_DIV_TWO;
            dav_pkg::ST_DIV_TWO:   n_state = dav_pkg::ST_WAIT_TWO;
            dav_pkg::ST_WAIT_TWO:  if (w_div_done) n_state = dav_pkg::ST_FINISH;
            dav_pkg::ST_FINISH:    n_state = dav_pkg::ST_OUT;
            dav_pkg::ST_OUT:       if (w_out_free) n_state = dav_pkg::ST_IDLE;
            default:               n_state = dav_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall     = 1'b1;
        w_sel_two   = 1'b0;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            dav_pkg::ST_IDLE:      o_stall     = 1'b0;
            dav_pkg::ST_SCALE_TWO: w_sel_two   = 1'b1;
            dav_pkg::ST_DIV_ONE:   w_div_start = 1'b1;
            dav_pkg::ST_DIV_TWO:   w_div_start = 1'b1;
            dav_pkg::ST_OUT:       w_load      = w_out_free;
            default: ;
        endcase
    end

    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dav_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- scaling, one channel per cycle ----------------
    assign w_scale_raw  = w_sel_two ? r_raw_two : r_raw_one;
    assign w_scale_gain = w_sel_two ? r_gain_two : r_gain_one;

    dav_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_scale (
        .i_clk     (i_clk),
        .i_raw     (w_scale_raw),
        .i_gain    (w_scale_gain),
        .i_gravity (r_gravity),
        .o_accel   (w_accel)
    );

    // ---------------- noise gate and accumulate ----------------
    assign w_mag_one = r_acc_one[AW-1] ? AW'(-r_acc_one) : AW'(r_acc_one);
    assign w_mag_two = w_accel[AW-1] ? AW'(-w_accel) : AW'(w_accel);
    assign w_thr_ext = AW'(r_threshold);
    assign w_quiet   = (w_mag_one < w_thr_ext) || (w_mag_two < w_thr_ext);
    assign w_add_one = w_quiet ? '0 : r_acc_one;
    assign w_add_two = w_quiet ? '0 : w_accel;
    assign w_tot_one = SUMW'(r_sum_one) + SUMW'(w_add_one);
    assign w_tot_two = SUMW'(r_sum_two) + SUMW'(w_add_two);

    always_comb begin
        if (w_tot_one > SUM_MAX) begin
            w_sat_one = SUM_MAX[ACC_WIDTH-1:0];
        end else if (w_tot_one < SUM_MIN) begin
            w_sat_one = SUM_MIN[ACC_WIDTH-1:0];
        end else begin
            w_sat_one = w_tot_one[ACC_WIDTH-1:0];
        end
        if (w_tot_two > SUM_MAX) begin
            w_sat_two = SUM_MAX[ACC_WIDTH-1:0];
        end else if (w_tot_two < SUM_MIN) begin
            w_sat_two = SUM_MIN[ACC_WIDTH-1:0];
        end else begin
            w_sat_two = w_tot_two[ACC_WIDTH-1:0];
        end
    end

    // count wraps past its top, and a wrap also closes the window
    assign w_cnt_nx     = r_cnt + NW'(1);
    assign w_len        = (r_window == '0) ? NW'(1) : r_window;
    assign w_window_end = !((w_cnt_nx < w_len) && (w_cnt_nx != '0));

    // ---------------- shared divider ----------------
    assign w_div_dividend = (r_state == dav_pkg::ST_DIV_TWO) ? r_sum_two : r_sum_one;

    dav_div #(
        .WIDTH (ACC_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_len),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // ---------------- new speeds ----------------
    assign w_vsum_one = VW'(r_quo_one) + VW'(r_prev_one);
    assign w_vsum_two = VW'(r_quo_two) + VW'(r_prev_two);

    always_comb begin
        if (w_vsum_one > SPD_MAX) begin
            w_vsat_one = SPD_MAX[SPW-1:0];
        end else if (w_vsum_one < SPD_MIN) begin
            w_vsat_one = SPD_MIN[SPW-1:0];
        end else begin
            w_vsat_one = w_vsum_one[SPW-1:0];
        end
        if (w_vsum_two > SPD_MAX) begin
            w_vsat_two = SPD_MAX[SPW-1:0];
        end else if (w_vsum_two < SPD_MIN) begin
            w_vsat_two = SPD_MIN[SPW-1:0];
        end else begin
            w_vsat_two = w_vsum_two[SPW-1:0];
        end
    end

    // stop band is open on both sides, checked without wrap
    assign w_v_ext    = BW'(r_v_one);
    assign w_band_ext = $signed({{(BW - OW){1'b0}}, r_band});
    assign w_hi       = BW'(r_prev_one) + w_band_ext;
    assign w_lo       = BW'(r_prev_one) - w_band_ext;
    assign w_stop     = (w_v_ext < w_hi) && (w_v_ext > w_lo);

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_raw_one <= i_raw_one;
            r_raw_two <= i_raw_two;
        end
        if (r_state == dav_pkg::ST_SCALE_TWO) begin
            r_acc_one <= w_accel;
        end
        if (r_state == dav_pkg::ST_WAIT_ONE && w_div_done) begin
            r_quo_one <= w_div_quo;
        end
        if (r_state == dav_pkg::ST_WAIT_TWO && w_div_done) begin
            r_quo_two <= w_div_quo;
        end
        if (r_state == dav_pkg::ST_FINISH) begin
            r_v_one <= w_vsat_one;
            r_v_two <= w_vsat_two;
        end
        if (w_load) begin
            r_out_one  <= w_stop ? '0 : r_v_one;
            r_out_two  <= w_stop ? '0 : r_v_two;
            r_out_stop <= w_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_one   <= '0;
            r_sum_two   <= '0;
            r_prev_one  <= '0;
            r_prev_two  <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == dav_pkg::ST_ACCUM) begin
                r_sum_one <= w_sat_one;
                r_sum_two <= w_sat_two;
                r_cnt     <= w_cnt_nx;
            end
            if (r_state == dav_pkg::ST_FINISH) begin
                r_sum_one <= '0;
                r_sum_two <= '0;
                r_cnt     <= '0;
            end
            if (w_load) begin
                r_prev_one  <= w_stop ? '0 : r_v_one;
                r_prev_two  <= w_stop ? '0 : r_v_two;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_speed_one = r_out_one;
    assign o_speed_two = r_out_two;
    assign o_stopped   = r_out_stop;

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == dav_pkg::ST_OUT))
        else $error("result word raised outside the output step");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stopped |-> o_speed_one == '0 && o_speed_two == '0)
        else $error("stopped word carries nonzero speed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_speed_one) && $stable(o_speed_two)
            && $stable(o_stopped))
        else $error("stalled result word changed");

endmodule

// ----- rtl/core/dav_scale.sv -----
module dav_scale #(
    parameter int SAMPLE_WIDTH = dav_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                             i_clk,
    input  logic signed [SAMPLE_WIDTH-1:0]                   i_raw,
    input  logic        [dav_pkg::GAIN_WIDTH-1:0]            i_gain,
    input  logic        [dav_pkg::OFFSET_WIDTH-1:0]          i_gravity,
    output logic signed [dav_pkg::f_accel_width(SAMPLE_WIDTH)-1:0] o_accel
);

    localparam int AW = dav_pkg::f_accel_width(SAMPLE_WIDTH);
    localparam int PW = SAMPLE_WIDTH + dav_pkg::GAIN_WIDTH + 1;
    localparam int SW = PW - 8;

    logic signed [PW-1:0] w_raw_ext;
    logic signed [PW-1:0] w_gain_ext;
    logic signed [PW-1:0] w_prod;
    logic signed [SW-1:0] w_floor;
    logic signed [AW-1:0] w_gravity;
    logic signed [AW-1:0] n_accel;
    logic signed [AW-1:0] r_accel;

    assign w_raw_ext  = PW'(i_raw);
    assign w_gain_ext = $signed({{(PW - dav_pkg::GAIN_WIDTH){1'b0}}, i_gain});
    assign w_prod     = w_raw_ext * w_gain_ext;
    // dropping the low byte of a two's complement product rounds toward minus infinity
    assign w_floor    = w_prod[PW-1:8];
    assign w_gravity  = $signed({{(AW - dav_pkg::OFFSET_WIDTH){1'b0}}, i_gravity});
    assign n_accel    = AW'(w_floor) - w_gravity;

    always_ff @(posedge i_clk) begin
        r_accel <= n_accel;
    end

    assign o_accel = r_accel;

endmodule

// ----- rtl/core/dav_div.sv -----
module dav_div #(
    parameter int WIDTH = dav_pkg::ACC_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [WIDTH-1:0]              i_dividend,
    input  logic        [dav_pkg::WINDOW_WIDTH-1:0] i_divisor,
    output logic                                 o_done,
    output logic signed [WIDTH:0]                o_quotient
);

    localparam int CW = $clog2(WIDTH + 1);
    localparam int DW = dav_pkg::WINDOW_WIDTH;

    logic             r_busy;
    logic             n_busy;
    logic             r_done;
    logic             n_done;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    n_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] n_quo;
    logic             r_neg;
    logic             n_neg;
    logic [DW:0]      w_rem_sh;
    logic             w_ge;
    logic [DW:0]      w_rem_sub;

    // one quotient bit per cycle, restoring
    assign w_rem_sh  = {r_rem, r_quo[WIDTH-1]};
    assign w_ge      = w_rem_sh >= {1'b0, i_divisor};
    assign w_rem_sub = w_rem_sh - {1'b0, i_divisor};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(WIDTH);
            n_rem  = '0;
            n_neg  = i_dividend[WIDTH-1];
            // magnitude; the most negative value maps to its unsigned bit pattern
            n_quo  = i_dividend[WIDTH-1] ? WIDTH'(-i_dividend) : WIDTH'(i_dividend);
        end else if (r_busy) begin
            n_rem = w_ge ? w_rem_sub[DW-1:0] : w_rem_sh[DW-1:0];
            n_quo = {r_quo[WIDTH-2:0], w_ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_neg <= n_neg;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("divider done without a finished run");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < i_divisor)
        else $error("divider remainder out of range");

endmodule

// ----- test/tb_dual_accel_velocity_integrator.sv -----
`timescale 1ns / 1ps

module tb_dual_accel_velocity_integrator;

    localparam int  ACC_W       = dav_pkg::ACC_WIDTH_DEF;
    localparam int  GAIN_W      = dav_pkg::GAIN_WIDTH;
    localparam int  OFS_W       = dav_pkg::OFFSET_WIDTH;
    localparam int  WIN_W       = dav_pkg::WINDOW_WIDTH;
    localparam int  SPD_W       = dav_pkg::SPEED_WIDTH;
    localparam int  IDX_W       = dav_pkg::CFG_INDEX_WIDTH;
    localparam int  DATA_W      = dav_pkg::CFG_DATA_WIDTH;
    localparam int  IDLE_PAUSE  = 2 * ACC_W + 40;
    localparam int  ITEM_TARGET = 1450;
    localparam int  RUN_LIMIT   = 2000000;
    localparam logic [IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam logic [OFS_W-1:0] OFFSET_MAX       = 21'h1FFFFF;

    typedef struct {
        logic signed [15:0] raw_one;
        logic signed [15:0] raw_two;
    } t_sample_pair;

    typedef struct {
        logic signed [SPD_W-1:0] speed_one;
        logic signed [SPD_W-1:0] speed_two;
        logic                    stopped;
    } t_speed_rec;

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_valid     = 1'b0;
    logic                    o_stall;
    logic signed [15:0]      i_raw_one   = '0;
    logic signed [15:0]      i_raw_two   = '0;
    logic                    o_valid;
    logic                    i_stall     = 1'b0;
    logic signed [SPD_W-1:0] o_speed_one;
    logic signed [SPD_W-1:0] o_speed_two;
    logic                    o_stopped;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [IDX_W-1:0]        i_cfg_index = '0;
    logic [DATA_W-1:0]       i_cfg_data  = '0;

    dual_accel_velocity_integrator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_raw_one   (i_raw_one),
        .i_raw_two   (i_raw_two),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_speed_one (o_speed_one),
        .o_speed_two (o_speed_two),
        .o_stopped   (o_stopped),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow registers
    logic [GAIN_W-1:0] gain_one_cfg  = dav_pkg::GAIN_ONE_RST;
    logic [GAIN_W-1:0] gain_two_cfg  = dav_pkg::GAIN_TWO_RST;
    logic [OFS_W-1:0]  gravity_cfg   = dav_pkg::GRAVITY_RST;
    logic [OFS_W-1:0]  threshold_cfg = dav_pkg::THRESHOLD_RST;
    logic [WIN_W-1:0]  window_cfg    = dav_pkg::WINDOW_RST;
    logic [OFS_W-1:0]  stop_band_cfg = dav_pkg::STOP_BAND_RST;

    // integrator state
    longint            accum_one      = 0;
    longint            accum_two      = 0;
    longint            last_speed_one = 0;
    longint            last_speed_two = 0;
    logic [WIN_W-1:0]  fill_count     = '0;

    t_sample_pair pending_pairs[$];
    t_speed_rec   expected_speeds[$];
    t_sample_pair next_pair;

    bit quiet    = 1'b0;
    bit in_taken = 1'b0;
    int fail_count     = 0;
    int pairs_taken    = 0;
    int windows_closed = 0;
    int stop_hits      = 0;
    int sat_hits       = 0;
    int settings_used  = 0;
    int cycle_count    = 0;

    function automatic longint clamp_signed(input longint x, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    // raw*gain floored by 256, gravity removed
    function automatic longint scaled_accel(input logic signed [15:0] raw,
                                            input logic [GAIN_W-1:0] gain);
        longint prod;
        prod = longint'(raw) * longint'(gain);
        return (prod >>> 8) - longint'(gravity_cfg);
    endfunction

    task automatic integrate_sample(input logic signed [15:0] r1, input logic signed [15:0] r2);
        longint     a1;
        longint     a2;
        longint     n;
        longint     v1;
        longint     v2;
        bit         stop;
        t_speed_rec rec;
        a1 = scaled_accel(r1, gain_one_cfg);
        a2 = scaled_accel(r2, gain_two_cfg);
        n  = (window_cfg == '0) ? longint'(1) : longint'(window_cfg);
        if ((a1 < 0 ? -a1 : a1) < longint'(threshold_cfg) ||
            (a2 < 0 ? -a2 : a2) < longint'(threshold_cfg)) begin
            a1 = 0;
            a2 = 0;
        end
        accum_one  = clamp_signed(accum_one + a1, ACC_W);
        accum_two  = clamp_signed(accum_two + a2, ACC_W);
        fill_count = fill_count + WIN_W'(1);
        if (longint'(fill_count) < n && fill_count != '0) return;
        v1 = clamp_signed(accum_one / n + last_speed_one, SPD_W);
        v2 = clamp_signed(accum_two / n + last_speed_two, SPD_W);
        if (v1 >= 64'sd2147483647 || v1 <= -64'sd2147483648 ||
            v2 >= 64'sd2147483647 || v2 <= -64'sd2147483648) sat_hits++;
        stop = (v1 < last_speed_one + longint'(stop_band_cfg)) &&
               (v1 > last_speed_one - longint'(stop_band_cfg));
        if (stop) begin
            v1 = 0;
            v2 = 0;
            stop_hits++;
        end
        last_speed_one = v1;
        last_speed_two = v2;
        accum_one      = 0;
        accum_two      = 0;
        fill_count     = '0;
        rec.speed_one  = v1[SPD_W-1:0];
        rec.speed_two  = v2[SPD_W-1:0];
        rec.stopped    = stop;
        expected_speeds.push_back(rec);
        windows_closed++;
    endtask

    task automatic apply_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        case (dav_pkg::t_cfg_index'(idx))
            dav_pkg::CFG_GAIN_ONE:  gain_one_cfg  = data[GAIN_W-1:0];
            dav_pkg::CFG_GAIN_TWO:  gain_two_cfg  = data[GAIN_W-1:0];
            dav_pkg::CFG_GRAVITY:   gravity_cfg   = data[OFS_W-1:0];
            dav_pkg::CFG_THRESHOLD: threshold_cfg = data[OFS_W-1:0];
            dav_pkg::CFG_WINDOW:    window_cfg    = data[WIN_W-1:0];
            dav_pkg::CFG_STOP_BAND: stop_band_cfg = data[OFS_W-1:0];
            default: ;
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < RUN_LIMIT) @(posedge i_clk) cycle_count++;
        $display("timeout after %0d cycles", cycle_count);
        $display("dual_accel_velocity_integrator verification failed");
        $finish;
    end

    // sample driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pending_pairs.size() != 0 && (quiet || $urandom_range(0, 99) >= 33)) begin
                next_pair = pending_pairs.pop_front();
                i_valid   <= 1'b1;
                i_raw_one <= next_pair.raw_one;
                i_raw_two <= next_pair.raw_two;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= !quiet && ($urandom_range(0, 99) < 33);
        end
    end

    // monitor: results first, then new words into the predictor
    always @(posedge i_clk) begin
        t_speed_rec exp_rec;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_speeds.size() == 0) begin
                    $error("unexpected result: speed_one %0d speed_two %0d stopped %0b",
                           o_speed_one, o_speed_two, o_stopped);
                    fail_count++;
                end else begin
                    exp_rec = expected_speeds.pop_front();
                    if (o_speed_one !== exp_rec.speed_one) begin
                        $error("speed_one expected %0d actual %0d",
                               exp_rec.speed_one, o_speed_one);
                        fail_count++;
                    end
                    if (o_speed_two !== exp_rec.speed_two) begin
                        $error("speed_two expected %0d actual %0d",
                               exp_rec.speed_two, o_speed_two);
                        fail_count++;
                    end
                    if (o_stopped !== exp_rec.stopped) begin
                        $error("stopped expected %0b actual %0b", exp_rec.stopped, o_stopped);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) apply_reg(i_cfg_index, i_cfg_data);
            in_taken = i_valid && !o_stall;
            if (in_taken) begin
                integrate_sample(i_raw_one, i_raw_two);
                pairs_taken++;
            end
        end
    end

    task automatic push_pair(input logic signed [15:0] r1, input logic signed [15:0] r2);
        t_sample_pair p;
        p.raw_one = r1;
        p.raw_two = r2;
        pending_pairs.push_back(p);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // unused upper data bits carry noise, the block keeps only the register width
    task automatic program_regs(input logic [GAIN_W-1:0] g1, input logic [GAIN_W-1:0] g2,
                                input logic [OFS_W-1:0] grav,
                                input logic [OFS_W-1:0] thr,
                                input logic [WIN_W-1:0] win,
                                input logic [OFS_W-1:0] band);
        logic [DATA_W-1:0] d;
        d = DATA_W'($urandom);
        d[GAIN_W-1:0] = g1;
        write_reg(dav_pkg::CFG_GAIN_ONE, d);
        d = DATA_W'($urandom);
        d[GAIN_W-1:0] = g2;
        write_reg(dav_pkg::CFG_GAIN_TWO, d);
        write_reg(dav_pkg::CFG_GRAVITY, grav);
        write_reg(dav_pkg::CFG_THRESHOLD, thr);
        d = DATA_W'($urandom);
        d[WIN_W-1:0] = win;
        write_reg(dav_pkg::CFG_WINDOW, d);
        write_reg(dav_pkg::CFG_STOP_BAND, band);
        settings_used++;
    endtask

    task automatic wait_idle();
        while (pending_pairs.size() != 0 || i_valid || expected_speeds.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    // raw value whose scaled acceleration sits close to gravity
    function automatic logic signed [15:0] near_rest(input logic [GAIN_W-1:0] gain);
        longint t;
        t = (longint'(gravity_cfg) * 256) / longint'(gain)
            + longint'($urandom_range(0, 800)) - 400;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return t[15:0];
    endfunction

    function automatic logic signed [15:0] pick_raw(input logic [GAIN_W-1:0] gain);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return near_rest(gain);
        if (sel < 70) return 16'($urandom);
        if (sel < 85) begin
            case ($urandom_range(0, 3))
                0: return 16'sh7FFF;
                1: return 16'sh8000;
                2: return 16'sh0000;
                default: return -16'sd1;
            endcase
        end
        return 16'(int'($urandom_range(0, 512)) - 256);
    endfunction

    // zero both speeds through a stop, then drive one sign hard to hit the rails
    task automatic run_saturation(input bit negative, input logic [OFS_W-1:0] grav,
                                  input logic [WIN_W-1:0] win, input int count);
        program_regs(dav_pkg::GAIN_ONE_RST, dav_pkg::GAIN_TWO_RST, dav_pkg::GRAVITY_RST,
                     OFFSET_MAX, 8'd1, OFFSET_MAX);
        push_pair(16'($urandom), 16'($urandom));
        wait_idle();
        program_regs(16'hFFFF, 16'hFFFF, grav, '0, win, '0);
        for (int k = 0; k < count; k++) begin
            if (negative)
                push_pair(16'sh8000 + 16'($urandom_range(0, 7)),
                          16'sh8000 + 16'($urandom_range(0, 7)));
            else
                push_pair(16'sh7FFF - 16'($urandom_range(0, 7)),
                          16'sh7FFF - 16'($urandom_range(0, 7)));
        end
        wait_idle();
    endtask

    initial begin : stimulus
        int                phase;
        int                n_items;
        logic [GAIN_W-1:0] g1;
        logic [GAIN_W-1:0] g2;
        logic [OFS_W-1:0]  grav;
        logic [OFS_W-1:0]  thr;
        logic [WIN_W-1:0]  win;
        logic [OFS_W-1:0]  band;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-word windows on reset defaults: field extremes and a pair at rest
        write_reg(dav_pkg::CFG_WINDOW, 21'd1);
        push_pair(16'sh0000, 16'sh0000);
        push_pair(16'sh7FFF, 16'sh7FFF);
        push_pair(16'sh8000, 16'sh8000);
        push_pair(16'sh7FFF, 16'sh8000);
        push_pair(16'sh8000, 16'sh7FFF);
        push_pair(16'sd17900, 16'sd14570);
        push_pair(-16'sd1, 16'sd1);
        wait_idle();

        // zero window length acts as one
        write_reg(dav_pkg::CFG_WINDOW, 21'd0);
        push_pair(16'sh7FFF, 16'sh8000);
        push_pair(-16'sd1, 16'sd1);
        wait_idle();

        // window cut below the current fill closes on the next word
        write_reg(dav_pkg::CFG_WINDOW, 21'd200);
        for (int k = 0; k < 5; k++) push_pair(16'($urandom), 16'($urandom));
        wait_idle();
        write_reg(dav_pkg::CFG_WINDOW, 21'd3);
        push_pair(16'($urandom), 16'($urandom));
        wait_idle();

        // write to an unused index leaves every register alone
        write_reg(CFG_UNUSED_INDEX, OFFSET_MAX);
        for (int k = 0; k < 3; k++) push_pair(16'($urandom), 16'($urandom));
        wait_idle();

        phase = 0;
        while (pairs_taken < ITEM_TARGET || windows_closed < 40) begin
            quiet = (phase == 4);
            case (phase)
                2: run_saturation(1'b0, '0, 8'd1, 270);
                6: run_saturation(1'b1, OFFSET_MAX, 8'd1, 215);
                9: run_saturation(1'b1, OFFSET_MAX, 8'd255, 255);
                default: begin
                    case ($urandom_range(0, 9))
                        0: g1 = 16'd1;
                        1: g1 = 16'hFFFF;
                        default: g1 = GAIN_W'($urandom_range(1, 65535));
                    endcase
                    case ($urandom_range(0, 9))
                        0: g2 = 16'd1;
                        1: g2 = 16'hFFFF;
                        default: g2 = GAIN_W'($urandom_range(1, 65535));
                    endcase
                    case ($urandom_range(0, 9))
                        0: grav = '0;
                        1: grav = OFFSET_MAX;
                        2, 3, 4, 5: grav = dav_pkg::GRAVITY_RST;
                        default: grav = OFS_W'($urandom);
                    endcase
                    case ($urandom_range(0, 9))
                        0: thr = '0;
                        1: thr = OFFSET_MAX;
                        2, 3, 4, 5, 6: thr = OFS_W'($urandom_range(0, 40000));
                        default: thr = OFS_W'($urandom);
                    endcase
                    case ($urandom_range(0, 9))
                        0: win = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd200;
                        1: win = 8'd1;
                        default: win = WIN_W'($urandom_range(2, 12));
                    endcase
                    case ($urandom_range(0, 9))
                        0: band = '0;
                        1: band = OFFSET_MAX;
                        default: band = OFS_W'($urandom_range(0, 5000));
                    endcase
                    program_regs(g1, g2, grav, thr, win, band);
                    n_items = $urandom_range(20, 60);
                    for (int k = 0; k < n_items; k++)
                        push_pair(pick_raw(gain_one_cfg), pick_raw(gain_two_cfg));
                    wait_idle();
                end
            endcase
            phase++;
        end
        quiet = 1'b0;

        $display("covered %0d sample pairs under %0d register settings",
                 pairs_taken, settings_used);
        $display("%0d windows closed, %0d zeroed by the stop band, %0d hit a speed rail",
                 windows_closed, stop_hits, sat_hits);
        if (fail_count == 0) begin
            $display("dual_accel_velocity_integrator verification clean");
        end else begin
            $display("dual_accel_velocity_integrator verification failed");
        end
        $finish;
    end

endmodule
